FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/pwc_pkg.sv
// types and codes of the power window controller
package pwc_pkg;

	typedef struct packed {
		logic driver_up_pressed;
		logic driver_down_pressed;
		logic pass_up_pressed;
		logic pass_down_pressed;
		logic upper_limit_event;
		logic lower_limit_event;
		logic lock_toggle_event;
		logic jam_event;
	} pwc_in_t;

	typedef struct packed {
		logic [1:0] motor_drive;
		logic [2:0] motion_mode;
		logic       from_passenger;
		logic       stopped_now;
		logic [2:0] stop_cause;
		logic       lock_on;
		logic       at_upper;
		logic       at_lower;
	} pwc_out_t;

	localparam logic [1:0] DRIVE_STOP = 2'd0;
	localparam logic [1:0] DRIVE_UP   = 2'd1;
	localparam logic [1:0] DRIVE_DOWN = 2'd2;

	localparam logic [2:0] MODE_IDLE        = 3'd0;
	localparam logic [2:0] MODE_UP_AUTO     = 3'd1;
	localparam logic [2:0] MODE_UP_MANUAL   = 3'd2;
	localparam logic [2:0] MODE_DOWN_AUTO   = 3'd3;
	localparam logic [2:0] MODE_DOWN_MANUAL = 3'd4;

	localparam logic [2:0] CAUSE_RELEASED = 3'd0;
	localparam logic [2:0] CAUSE_LOCK     = 3'd1;
	localparam logic [2:0] CAUSE_JAM      = 3'd2;
	localparam logic [2:0] CAUSE_UPPER    = 3'd3;
	localparam logic [2:0] CAUSE_LOWER    = 3'd4;

	localparam logic REG_DEBOUNCE   = 1'b0;
	localparam logic REG_LONG_PRESS = 1'b1;

	localparam logic [9:0]  DEBOUNCE_RESET   = 10'd50;
	localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;

endpackage

FILE: rtl/power_window_controller_unit.sv
// power window controller top level
// One transfer on the input channel is one tick of sampled button levels and
// event pulses; each tick gives exactly one result transfer on the output
// channel with the motor command, motion mode, stop report and flags.
// The input transfer lands in a stage register; the tick is evaluated from
// there combinationally and written into the output register, which offers
// the result. One tick per cycle is sustained while out_ready stays high;
// the stage register and the output register let a new input transfer in
// while a finished result still waits.
// When the receiver stalls, the result is held, the stage register fills and
// then in_ready drops until out_ready returns.
// Reset clears the motion state, the classifier, all flags and both channels,
// and loads debounce_ticks = 50 and long_press_ticks = 1000.
// The APB port writes debounce_ticks at 0x0 and long_press_ticks at 0x4;
// pready is always high. Write the registers only while no tick is pending.
module power_window_controller_unit
	import pwc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  pwc_in_t     in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output pwc_out_t    out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [1:0] {
		PH_SCAN,
		PH_DEBOUNCE,
		PH_HOLD
	} phase_t;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	logic [9:0]  debounce_q;
	logic [15:0] long_press_q;

	logic        valid_s1;
	pwc_in_t     data_s1;
	logic        out_valid_q;
	pwc_out_t    out_data_q;
	logic        adv;

	logic [2:0]  mode_q;
	logic        src_q;
	phase_t      phase_q;
	logic [1:0]  button_q;
	logic [15:0] count_q;
	logic        lock_q;
	logic        jam_q;
	logic        upper_q;
	logic        lower_q;

	logic [2:0]  mode_n;
	logic        src_n;
	phase_t      phase_n;
	logic [1:0]  button_n;
	logic [15:0] count_n;
	logic        lock_n;
	logic        jam_n;
	logic        upper_n;
	logic        lower_n;
	logic        stopped;
	logic [2:0]  cause;
	pwc_out_t    res;

	logic [3:0]  btns;
	logic        moving;
	logic        up;
	logic        manual;
	logic [2:0]  mode_mid;
	logic        cls_en;
	logic        du_only;
	logic        found;
	logic [1:0]  idx;
	logic        conf;
	logic        held;
	logic [15:0] count_inc;
	logic [2:0]  nxt;
	logic        who;

	function automatic logic [2:0] motion_for(input logic [1:0] b, input logic man);
		if (!b[0]) begin
			motion_for = man ? MODE_UP_MANUAL : MODE_UP_AUTO;
		end else begin
			motion_for = man ? MODE_DOWN_MANUAL : MODE_DOWN_AUTO;
		end
	endfunction

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_LONG_PRESS) ? {16'b0, long_press_q} : {22'b0, debounce_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RESET;
			long_press_q <= LONG_PRESS_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == REG_DEBOUNCE) begin
				debounce_q <= pwdata[9:0];
			end else begin
				long_press_q <= pwdata[15:0];
			end
		end
	end

	// handshake
	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// tick evaluation
	assign btns = {data_s1.pass_down_pressed, data_s1.pass_up_pressed,
		data_s1.driver_down_pressed, data_s1.driver_up_pressed};
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + 16'd1;

	always_comb begin
		upper_n = upper_q | data_s1.upper_limit_event;
		lower_n = lower_q | data_s1.lower_limit_event;
		lock_n  = lock_q ^ data_s1.lock_toggle_event;
		jam_n   = jam_q | data_s1.jam_event;

		moving  = (mode_q == MODE_UP_AUTO) || (mode_q == MODE_UP_MANUAL) ||
			(mode_q == MODE_DOWN_AUTO) || (mode_q == MODE_DOWN_MANUAL);
		up      = (mode_q == MODE_UP_AUTO) || (mode_q == MODE_UP_MANUAL);
		manual  = (mode_q == MODE_UP_MANUAL) || (mode_q == MODE_DOWN_MANUAL);
		stopped = 1'b0;
		cause   = CAUSE_RELEASED;
		src_n   = src_q;
		phase_n = phase_q;
		mode_mid = MODE_IDLE;

		if (moving) begin
			if (manual && !btns[{src_q, ~up}]) begin
				stopped = 1'b1;
				cause   = CAUSE_RELEASED;
			end else if (lock_n) begin
				stopped = 1'b1;
				cause   = CAUSE_LOCK;
			end else if (jam_n) begin
				stopped = 1'b1;
				cause   = CAUSE_JAM;
				jam_n   = 1'b0;
			end else if (up && upper_n) begin
				stopped = 1'b1;
				cause   = CAUSE_UPPER;
			end else if (!up && lower_n) begin
				stopped = 1'b1;
				cause   = CAUSE_LOWER;
			end
			if (stopped) begin
				src_n   = 1'b0;
				phase_n = PH_SCAN;
			end else begin
				mode_mid = mode_q;
				if (up) begin
					lower_n = 1'b0;
				end else begin
					upper_n = 1'b0;
				end
			end
		end

		// button classification
		cls_en  = !stopped && ((mode_mid == MODE_IDLE) ||
			(mode_mid == MODE_DOWN_AUTO && src_q));
		du_only = (mode_mid != MODE_IDLE);
		if (du_only || btns[0]) begin
			found = btns[0];
			idx   = 2'd0;
		end else if (btns[1]) begin
			found = 1'b1;
			idx   = 2'd1;
		end else if (btns[2]) begin
			found = 1'b1;
			idx   = 2'd2;
		end else begin
			found = btns[3];
			idx   = 2'd3;
		end

		button_n = button_q;
		count_n  = count_q;
		nxt      = MODE_IDLE;
		who      = 1'b0;
		conf     = 1'b0;
		held     = 1'b0;
		if (cls_en) begin
			case (phase_q)
				PH_DEBOUNCE: begin
					count_n = count_inc;
					conf    = (count_inc >= {6'b0, debounce_q});
				end
				PH_HOLD: begin
					count_n = count_inc;
					held    = btns[button_q];
					if (!held || count_inc >= long_press_q) begin
						phase_n = PH_SCAN;
						who     = button_q[1];
						nxt     = motion_for(button_q, held);
					end
				end
				default: begin
					phase_n = PH_SCAN;
					if (found) begin
						button_n = idx;
						phase_n  = PH_DEBOUNCE;
						count_n  = '0;
						conf     = (debounce_q == '0);
					end
				end
			endcase
			if (conf) begin
				if (!btns[button_n]) begin
					phase_n = PH_SCAN;
				end else begin
					phase_n = PH_HOLD;
					count_n = '0;
					if (long_press_q == '0) begin
						phase_n = PH_SCAN;
						who     = button_n[1];
						nxt     = motion_for(button_n, 1'b1);
					end
				end
			end
		end

		mode_n = mode_mid;
		if (nxt != MODE_IDLE) begin
			mode_n = nxt;
			src_n  = who;
		end

		res.motor_drive    = (mode_n == MODE_UP_AUTO || mode_n == MODE_UP_MANUAL) ? DRIVE_UP :
			(mode_n == MODE_DOWN_AUTO || mode_n == MODE_DOWN_MANUAL) ? DRIVE_DOWN : DRIVE_STOP;
		res.motion_mode    = mode_n;
		res.from_passenger = (mode_n != MODE_IDLE) && src_n;
		res.stopped_now    = stopped;
		res.stop_cause     = stopped ? cause : CAUSE_RELEASED;
		res.lock_on        = lock_n;
		res.at_upper       = upper_n;
		res.at_lower       = lower_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_IDLE;
			src_q       <= 1'b0;
			phase_q     <= PH_SCAN;
			button_q    <= '0;
			count_q     <= '0;
			lock_q      <= 1'b0;
			jam_q       <= 1'b0;
			upper_q     <= 1'b0;
			lower_q     <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				mode_q      <= mode_n;
				src_q       <= src_n;
				phase_q     <= phase_n;
				button_q    <= button_n;
				count_q     <= count_n;
				lock_q      <= lock_n;
				jam_q       <= jam_n;
				upper_q     <= upper_n;
				lower_q     <= lower_n;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
		if (adv) begin
			out_data_q <= res;
		end
	end

endmodule

FILE: rtl/pwc_checker.sv
// port-level checker for the power window controller, with its bind
`include "assert_macros.svh"

module pwc_checker
	import pwc_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     out_valid,
	input logic     out_ready,
	input pwc_out_t out_data
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result transfer changed")
	`ASSERT_IMPL(a_stop_idle, clk, arst_n, out_valid && out_data.stopped_now, out_data.motion_mode == MODE_IDLE && out_data.motor_drive == DRIVE_STOP, "motion reported after stop")
	`ASSERT_IMPL(a_cause_zero, clk, arst_n, out_valid && !out_data.stopped_now, out_data.stop_cause == CAUSE_RELEASED, "stop cause without stop")
	`ASSERT_IMPL(a_idle_drive, clk, arst_n, out_valid && out_data.motion_mode == MODE_IDLE, out_data.motor_drive == DRIVE_STOP && !out_data.from_passenger, "drive or source while idle")

endmodule

bind power_window_controller_unit pwc_checker u_pwc_checker (.*);
